// ===== hdl/ldf_pkg.sv =====
// ----------------------------------------------------------------------------
// ldf_pkg
// Shared types and constants of the link frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package ldf_pkg;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'b1;

    localparam logic [7:0]  SYNC_RESET   = 8'hA5;
    localparam logic [15:0] MAXPAY_RESET = 16'd1500;

    // Header bytes after the sync byte
    localparam logic [2:0] HDR_BYTES = 3'd7;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    // Header as gathered, first received byte in the top bits
    typedef struct packed {
        logic [7:0]  frame_type;
        logic [7:0]  frame_flags;
        logic [15:0] payload_length;
        logic [15:0] sequence_res;
        logic [7:0]  header_check;
    } t_header;

    typedef struct packed {
        logic        status;
        logic [7:0]  frame_type;
        logic [7:0]  frame_flags;
        logic [15:0] sequence_res;
        logic [15:0] payload_length;
        logic [7:0]  header_check;
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/ldf_if.sv =====
// ----------------------------------------------------------------------------
// ldf_rx_if / ldf_res_if
// Valid/ready channels of the link frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ldf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ldf_res_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [15:0] sequence_res;
    logic [15:0] payload_length;
    logic [7:0]  header_check;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        last;

    modport source (
        output valid, output status, output frame_type, output frame_flags,
        output sequence_res, output payload_length, output header_check,
        output data_byte, output data_valid, output last,
        input  ready
    );
    modport sink (
        input  valid, input status, input frame_type, input frame_flags,
        input  sequence_res, input payload_length, input header_check,
        input  data_byte, input data_valid, input last,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/link_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// link_frame_deframer
// Byte-serial receiver for length-prefixed link frames.
// ----------------------------------------------------------------------------
// Usage:
//   i_rx carries one received byte per request (valid/ready). Bytes are
//   discarded until the sync byte is seen, then seven header bytes are
//   gathered (type, flags, length, sequence, check). Each payload byte gives
//   one result on o_res with the header fields; the final byte has last set.
//   A zero length gives one header-only result, a length above max_payload
//   one drop result with status set; both carry last.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index (0 sync
//   byte, 1 max payload); the user must write only while the block is idle,
//   which the block itself does not enforce.
//   Path: input register, combinational parser, then the result register.
//   Throughput: one byte per cycle while the result sink is ready, set by the
//   single input register and single result register around the parser.
//   Reset: synchronous, clears both stages and returns to hunting with the
//   registers at sync 0xA5 and max payload 1500.
//   Receiver stall: the result register holds; the parser then holds the
//   buffered byte and i_rx.ready drops once the input register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module link_frame_deframer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    ldf_rx_if.sink                             i_rx,
    ldf_res_if.source                          o_res,
    input  wire logic                          i_cfg_we,
    input  wire logic [ldf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ldf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [7:0]       r_sync_byte;
    logic [15:0]      r_max_payload;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;

    logic             r_out_valid;
    ldf_pkg::t_result r_out;

    logic             w_out_free;
    logic             w_consume;
    logic             w_accept;
    logic             w_core_valid;
    ldf_pkg::t_result w_core_res;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_consume  = r_in_valid && w_out_free;
    assign i_rx.ready = !r_in_valid || w_consume;
    assign w_accept   = i_rx.valid && i_rx.ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte   <= ldf_pkg::SYNC_RESET;
            r_max_payload <= ldf_pkg::MAXPAY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ldf_pkg::CFG_SYNC_BYTE:   r_sync_byte   <= i_cfg_data[7:0];
                ldf_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    ldf_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_consume),
        .i_byte        (r_in_byte),
        .i_sync_byte   (r_sync_byte),
        .i_max_payload (r_max_payload),
        .o_res_valid   (w_core_valid),
        .o_res         (w_core_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_core_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_core_valid) begin
            r_out <= w_core_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_out.status;
    assign o_res.frame_type     = r_out.frame_type;
    assign o_res.frame_flags    = r_out.frame_flags;
    assign o_res.sequence_res   = r_out.sequence_res;
    assign o_res.payload_length = r_out.payload_length;
    assign o_res.header_check   = r_out.header_check;
    assign o_res.data_byte      = r_out.data_byte;
    assign o_res.data_valid     = r_out.data_valid;
    assign o_res.last           = r_out.last;

`ifndef SYNTHESIS
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_rx.ready)
        else $error("input stalled with empty result register");

    a_mid_frame_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_out.data_valid && !r_out.status))
        else $error("non-final result without payload byte");

    a_drop_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status) |-> (r_out.last && !r_out.data_valid
                                           && (r_out.data_byte == 8'd0)))
        else $error("malformed drop result");

    a_core_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_core_valid |-> w_out_free)
        else $error("result produced while result register full");
`endif

endmodule

`default_nettype wire

// ===== hdl/ldf_core.sv =====
// ----------------------------------------------------------------------------
// ldf_core
// Frame parser: sync hunt, header gathering and payload counting per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ldf_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_byte,
    input  wire logic [7:0]      i_sync_byte,
    input  wire logic [15:0]     i_max_payload,
    output logic                 o_res_valid,
    output ldf_pkg::t_result     o_res
);

    ldf_pkg::t_phase  r_phase, n_phase;
    logic [2:0]       r_hdr_cnt, n_hdr_cnt;
    logic [15:0]      r_pay_cnt, n_pay_cnt;
    ldf_pkg::t_header r_hdr, n_hdr;

    ldf_pkg::t_header w_shift_hdr;
    logic             w_hdr_full;
    logic             w_len_over;
    logic             w_len_zero;
    logic [15:0]      w_pay_inc;
    logic             w_pay_last;

    assign w_shift_hdr = ldf_pkg::t_header'({r_hdr[47:0], i_byte});
    assign w_hdr_full  = ((r_hdr_cnt + 3'd1) == ldf_pkg::HDR_BYTES);
    assign w_len_over  = (w_shift_hdr.payload_length > i_max_payload);
    assign w_len_zero  = (w_shift_hdr.payload_length == 16'd0);
    assign w_pay_inc   = r_pay_cnt + 16'd1;
    assign w_pay_last  = (w_pay_inc >= r_hdr.payload_length);

    // Next state
    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_pay_cnt = r_pay_cnt;
        n_hdr     = r_hdr;
        if (i_valid) begin
            case (r_phase)
                ldf_pkg::PH_HEADER: begin
                    n_hdr     = w_shift_hdr;
                    n_hdr_cnt = r_hdr_cnt + 3'd1;
                    if (w_hdr_full) begin
                        n_pay_cnt = 16'd0;
                        n_hdr_cnt = 3'd0;
                        if (w_len_over || w_len_zero) begin
                            n_phase   = ldf_pkg::PH_HUNT;
                        end else begin
                            n_phase = ldf_pkg::PH_PAYLOAD;
                        end
                    end
                end
                ldf_pkg::PH_PAYLOAD: begin
                    n_pay_cnt = w_pay_inc;
                    if (w_pay_last) begin
                        n_phase   = ldf_pkg::PH_HUNT;
                        n_hdr_cnt = 3'd0;
                        n_pay_cnt = 16'd0;
                    end
                end
                default: begin
                    if (i_byte == i_sync_byte) begin
                        n_phase   = ldf_pkg::PH_HEADER;
                        n_hdr_cnt = 3'd0;
                        n_pay_cnt = 16'd0;
                    end else begin
                        n_phase = ldf_pkg::PH_HUNT;
                    end
                end
            endcase
        end
    end

    // Result
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_phase)
            ldf_pkg::PH_HEADER: begin
                o_res_valid          = i_valid && w_hdr_full && (w_len_over || w_len_zero);
                o_res.status         = w_len_over;
                o_res.frame_type     = w_shift_hdr.frame_type;
                o_res.frame_flags    = w_shift_hdr.frame_flags;
                o_res.sequence_res   = w_shift_hdr.sequence_res;
                o_res.payload_length = w_shift_hdr.payload_length;
                o_res.header_check   = w_shift_hdr.header_check;
                o_res.last           = 1'b1;
            end
            ldf_pkg::PH_PAYLOAD: begin
                o_res_valid          = i_valid;
                o_res.frame_type     = r_hdr.frame_type;
                o_res.frame_flags    = r_hdr.frame_flags;
                o_res.sequence_res   = r_hdr.sequence_res;
                o_res.payload_length = r_hdr.payload_length;
                o_res.header_check   = r_hdr.header_check;
                o_res.data_byte      = i_byte;
                o_res.data_valid     = 1'b1;
                o_res.last           = w_pay_last;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ldf_pkg::PH_HUNT;
            r_hdr_cnt <= 3'd0;
            r_pay_cnt <= 16'd0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_pay_cnt <= n_pay_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

`ifndef SYNTHESIS
    a_no_res_without_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_valid)
        else $error("result without a consumed byte");

    a_hdr_cnt_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != ldf_pkg::PH_HEADER) |-> (r_hdr_cnt == 3'd0))
        else $error("header count left over outside header phase");

    a_payload_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_phase == ldf_pkg::PH_PAYLOAD) |-> $past(r_phase == ldf_pkg::PH_HEADER))
        else $error("payload phase entered without header");
`endif

endmodule

`default_nettype wire

// ===== sim/ldf_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_frame_checker
// Watches the byte and result channels of the deframer and the register write
// port. It keeps its own copy of the parser state, works out the results the
// accepted bytes should give, and compares every result in order, field by
// field.
// ----------------------------------------------------------------------------
module ldf_frame_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ldf_rx_if                             i_rx,
    ldf_res_if                            i_res,
    input  logic                          i_cfg_we,
    input  logic [ldf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ldf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count,
    output int                            o_drop_count,
    output int                            o_empty_count,
    output logic                          o_hunting
);
    import ldf_pkg::*;

    localparam logic ST_DATA = 1'b0;
    localparam logic ST_DROP = 1'b1;

    t_phase      rx_phase;
    logic [2:0]  hdr_count;
    t_header     hdr;
    logic [15:0] pay_count;
    logic [7:0]  sync_val;
    logic [15:0] max_len;
    t_result     expected_results[$];

    function automatic t_result frame_result(input logic status, input logic [7:0] data,
                                             input logic data_valid, input logic last);
        t_result r;
        r.status         = status;
        r.frame_type     = hdr.frame_type;
        r.frame_flags    = hdr.frame_flags;
        r.sequence_res   = hdr.sequence_res;
        r.payload_length = hdr.payload_length;
        r.header_check   = hdr.header_check;
        r.data_byte      = data;
        r.data_valid     = data_valid;
        r.last           = last;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] frame check: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d field %s is 0x%0h, predicted 0x%0h",
                                      o_result_count, name, got, want));
        end
    endtask

    task automatic restart_hunt();
        rx_phase  = PH_HUNT;
        hdr_count = '0;
        hdr       = '0;
        pay_count = '0;
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        case (rx_phase)
            PH_HEADER: begin
                hdr       = {hdr[47:0], b};
                hdr_count = hdr_count + 3'd1;
                if (hdr_count == HDR_BYTES) begin
                    if (hdr.payload_length > max_len) begin
                        expected_results.push_back(frame_result(ST_DROP, 8'h00, 1'b0, 1'b1));
                        o_drop_count++;
                        restart_hunt();
                    end else if (hdr.payload_length == 16'd0) begin
                        expected_results.push_back(frame_result(ST_DATA, 8'h00, 1'b0, 1'b1));
                        o_empty_count++;
                        restart_hunt();
                    end else begin
                        rx_phase  = PH_PAYLOAD;
                        pay_count = '0;
                    end
                end
            end
            PH_PAYLOAD: begin
                pay_count = pay_count + 16'd1;
                if (pay_count >= hdr.payload_length) begin
                    // push before the header is cleared
                    expected_results.push_back(frame_result(ST_DATA, b, 1'b1, 1'b1));
                    restart_hunt();
                end else begin
                    expected_results.push_back(frame_result(ST_DATA, b, 1'b1, 1'b0));
                end
            end
            default: begin
                if (b == sync_val) begin
                    restart_hunt();
                    rx_phase = PH_HEADER;
                end
            end
        endcase
    endtask

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing predicted",
                                      o_result_count));
        end else begin
            want = expected_results.pop_front();
            check_field("status", 16'(i_res.status), 16'(want.status));
            check_field("frame_type", 16'(i_res.frame_type), 16'(want.frame_type));
            check_field("frame_flags", 16'(i_res.frame_flags), 16'(want.frame_flags));
            check_field("sequence_res", i_res.sequence_res, want.sequence_res);
            check_field("payload_length", i_res.payload_length, want.payload_length);
            check_field("header_check", 16'(i_res.header_check), 16'(want.header_check));
            check_field("data_byte", 16'(i_res.data_byte), 16'(want.data_byte));
            check_field("data_valid", 16'(i_res.data_valid), 16'(want.data_valid));
            check_field("last", 16'(i_res.last), 16'(want.last));
        end
        o_result_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sync_val = SYNC_RESET;
            max_len  = MAXPAY_RESET;
            restart_hunt();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SYNC_BYTE:   sync_val = i_cfg_data[7:0];
                    CFG_MAX_PAYLOAD: max_len  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_rx.valid === 1'b1 && i_rx.ready === 1'b1) begin
                parse_rx_byte(i_rx.rx_byte);
            end
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                check_result();
            end
        end
        o_pending = expected_results.size();
        o_hunting = (rx_phase == PH_HUNT);
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the link frame deframer: a short directed set of frames, then
// random frames, noise and cut-off headers over several register settings,
// with bursty byte requests and a stalling result sink. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import ldf_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_BYTES   = 230;
    localparam int NUM_PHASES    = 7;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_LIGHT,
        SINK_HEAVY,
        SINK_PERIODIC
    } t_sink_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ldf_rx_if  rx_ch ();
    ldf_res_if res_ch ();

    int         fail_count, pending, result_count, drop_count, empty_count;
    logic       hunting;
    int         bytes_sent, frames_sent, cycle_count, burst_left;
    logic [7:0] cur_sync;
    logic [15:0] cur_max;
    t_sink_mode sink_mode = SINK_OPEN;
    int         sink_left, sink_tick;

    always #2 i_clk = ~i_clk;

    link_frame_deframer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ldf_frame_checker u_frame_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx           (rx_ch),
        .i_res          (res_ch),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_drop_count   (drop_count),
        .o_empty_count  (empty_count),
        .o_hunting      (hunting)
    );

    // Result sink: switch at random between stall patterns
    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
            sink_left <= $urandom_range(16, 160);
        end else begin
            sink_left <= sink_left - 1;
        end
        sink_tick <= sink_tick + 1;
        case (sink_mode)
            SINK_OPEN:  res_ch.ready <= 1'b1;
            SINK_LIGHT: res_ch.ready <= ($urandom_range(0, 3) != 0);
            SINK_HEAVY: res_ch.ready <= ($urandom_range(0, 3) == 0);
            default:    res_ch.ready <= ((sink_tick % 11) >= 7);
        endcase
    end

    function automatic int next_burst();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(30, 120);
        end
        return $urandom_range(1, 12);
    endfunction

    function automatic logic [7:0] payload_byte();
        logic [7:0] v;
        v = 8'($urandom);
        // the sync value turns up inside frames often enough to matter
        if ($urandom_range(0, 7) == 0) begin
            v = cur_sync;
        end
        return v;
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] v;
        v = 8'($urandom);
        if (v == cur_sync) begin
            v = v ^ 8'h01;
        end
        return v;
    endfunction

    // Hold the request until taken; close the burst with a random gap
    task automatic send_byte(input logic [7:0] b);
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (rx_ch.ready !== 1'b1);
        bytes_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = next_burst();
        end
    endtask

    task automatic drive_frame(input logic [7:0] ftype, input logic [7:0] flags,
                               input logic [15:0] len, input logic [15:0] seq,
                               input logic [7:0] check, input int n_payload);
        send_byte(cur_sync);
        send_byte(ftype);
        send_byte(flags);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(seq[15:8]);
        send_byte(seq[7:0]);
        send_byte(check);
        for (int i = 0; i < n_payload; i++) begin
            send_byte(payload_byte());
        end
        frames_sent++;
    endtask

    // Idle the link: finish any open frame with noise, let every result
    // drain, then give the parser time to settle
    task automatic drain_link();
        rx_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (!hunting) begin
            @(posedge i_clk);
            send_byte(noise_byte());
            rx_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] sync_word, input logic [15:0] max_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SYNC_BYTE;
        cfg_data  <= sync_word;
        @(posedge i_clk);
        cfg_index <= CFG_MAX_PAYLOAD;
        cfg_data  <= max_word;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cur_sync = sync_word[7:0];
        cur_max  = max_word;
    endtask

    task automatic traffic_step();
        int          pick;
        int          len_top;
        logic [15:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 2 && cur_max < 16'd4096) begin
            // cut-off header: the next bytes complete it
            send_byte(cur_sync);
            repeat ($urandom_range(1, 6)) send_byte(payload_byte());
        end else if (pick < 8) begin
            repeat ($urandom_range(1, 4)) send_byte(noise_byte());
        end else if (pick < 16) begin
            drive_frame(8'($urandom), 8'($urandom), 16'd0, 16'($urandom), 8'($urandom), 0);
        end else if (pick < 26 && cur_max != 16'hFFFF) begin
            len = 16'($urandom_range(int'(cur_max) + 1, 65535));
            drive_frame(8'($urandom), 8'($urandom), len, 16'($urandom), 8'($urandom), 0);
        end else if (cur_max == 16'd0) begin
            drive_frame(8'($urandom), 8'($urandom), 16'd0, 16'($urandom), 8'($urandom), 0);
        end else begin
            len_top = (pick >= 96) ? 300 : 16;
            if (len_top > int'(cur_max)) begin
                len_top = int'(cur_max);
            end
            len = 16'($urandom_range(1, len_top));
            drive_frame(8'($urandom), 8'($urandom), len, 16'($urandom), 8'($urandom),
                        int'(len));
        end
    endtask

    task automatic run_phase(input int p);
        logic [7:0]  new_sync;
        logic [15:0] max_word;
        logic [15:0] sync_word;
        int          target;
        case (p)
            0: begin
                new_sync = SYNC_RESET;
                max_word = MAXPAY_RESET;
            end
            1: begin
                new_sync = 8'h00;
                max_word = 16'h0000;
            end
            2: begin
                new_sync = 8'hFF;
                max_word = 16'hFFFF;
            end
            3: begin
                new_sync = 8'($urandom);
                max_word = 16'($urandom_range(1, 40));
            end
            4: begin
                new_sync = 8'($urandom);
                max_word = 16'($urandom_range(0, 2000));
            end
            5: begin
                new_sync = 8'($urandom);
                max_word = 16'($urandom_range(1, 12));
            end
            default: begin
                new_sync = SYNC_RESET;
                max_word = MAXPAY_RESET;
            end
        endcase
        // upper bits of the sync write are don't-care for the block
        sync_word      = 16'($urandom);
        sync_word[7:0] = new_sync;
        write_regs(sync_word, max_word);

        // length at the limit is kept, one above it is dropped
        if (cur_max <= 16'd32) begin
            drive_frame(8'($urandom), 8'($urandom), cur_max, 16'($urandom), 8'($urandom),
                        int'(cur_max));
        end
        if (cur_max != 16'hFFFF) begin
            drive_frame(8'($urandom), 8'($urandom), cur_max + 16'd1, 16'($urandom),
                        8'($urandom), 0);
        end

        target = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target) begin
            traffic_step();
        end
        drain_link();
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, pending);
        $display("link_frame_deframer: mismatch");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_SYNC_BYTE;
        cfg_data      <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        cur_sync   = SYNC_RESET;
        cur_max    = MAXPAY_RESET;
        burst_left = next_burst();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset settings
        send_byte(8'h00);
        send_byte(8'hFF);
        drive_frame(8'hFF, 8'h00, 16'h0000, 16'hFFFF, 8'h5A, 0);
        drive_frame(SYNC_RESET, 8'hFF, 16'd2, 16'h0000, SYNC_RESET, 2);
        drive_frame(8'h00, SYNC_RESET, 16'hFFFF, 16'h8001, 8'hFF, 0);
        drain_link();

        for (int p = 0; p < NUM_PHASES; p++) begin
            run_phase(p);
        end

        $display("Sent %0d bytes in %0d frames over %0d register settings, sync 0x00 to 0xFF",
                 bytes_sent, frames_sent, NUM_PHASES);
        $display("Compared %0d results (%0d dropped frames, %0d header-only), %0d failures",
                 result_count, drop_count, empty_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("link_frame_deframer: match");
        end else begin
            $display("link_frame_deframer: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ldf_pkg.sv
hdl/ldf_if.sv
hdl/ldf_core.sv
hdl/link_frame_deframer.sv
sim/ldf_frame_checker.sv
sim/tb.sv
